>>> rtl/gsr_pkg.sv
package gsr_pkg;

	// Row and column positions carry one spare bit so that a step past either
	// edge, including a step below zero, lands at or beyond the grid size.
	localparam int POS_W = 6;
	localparam int LEN_W = 5;

	localparam logic CMD_PLACE = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	typedef enum logic [1:0] {
		HEAD_NORTH = 2'd0,
		HEAD_SOUTH = 2'd1,
		HEAD_EAST  = 2'd2,
		HEAD_WEST  = 2'd3
	} heading_t;

endpackage

>>> rtl/gsr_ram.sv
module gsr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

>>> rtl/grid_segment_reserve_unit.sv
// Place: the run is first checked cell by cell, each cell read while the one before is judged,
// then marked cell by cell with a read and a write of its row in the row memory.
// A blocked or off-grid run ends at the first bad cell; clear and zero length skip both walks.
// One item is in work at a time; the input stalls until its result is in the output register.
// Reset (arst_n low) frees every cell at once through per-row valid bits and empties the output.
module grid_segment_reserve_unit import gsr_pkg::*; #(
	parameter int GRID_SIZE = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       command,
	input  logic [4:0] start_row,
	input  logic [4:0] start_col,
	input  logic [1:0] heading,
	input  logic [4:0] run_length,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       placed
);

	localparam int AW = $clog2(GRID_SIZE);
	localparam logic [POS_W-1:0] GRID_LIM = POS_W'(GRID_SIZE);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_MARK_RD,
		ST_MARK_WR,
		ST_DONE
	} state_t;

	state_t           state_q;
	logic [POS_W-1:0] r_q, c_q, r0_q, c0_q;
	logic [POS_W-1:0] r_next, c_next;
	logic [LEN_W-1:0] remain_q, len_q;
	heading_t         head_q;
	logic             ok_q;
	logic             out_valid_q, placed_q;
	logic [GRID_SIZE-1:0] row_valid_q;

	// Read stage of the cell walk.
	logic             v_s1;
	logic             rowv_s1;
	logic [AW-1:0]    col_s1;

	logic                 in_grid, issue, cell_hit;
	logic                 rd_en, wr_en;
	logic [GRID_SIZE-1:0] rd_data, wr_data, bit_mask;

	// The one stepping unit, shared by the check walk and the mark walk.
	always_comb begin
		r_next = r_q;
		c_next = c_q;
		unique case (head_q)
			HEAD_NORTH: r_next = r_q - POS_W'(1);
			HEAD_SOUTH: r_next = r_q + POS_W'(1);
			HEAD_EAST:  c_next = c_q + POS_W'(1);
			HEAD_WEST:  c_next = c_q - POS_W'(1);
		endcase
	end

	assign in_grid  = (r_q < GRID_LIM) && (c_q < GRID_LIM);
	assign issue    = (remain_q != '0);
	assign cell_hit = v_s1 && rowv_s1 && rd_data[col_s1];
	assign bit_mask = {{(GRID_SIZE-1){1'b0}}, 1'b1} << c_q[AW-1:0];
	assign wr_data  = (rowv_s1 ? rd_data : '0) | bit_mask;
	assign rd_en    = ((state_q == ST_CHECK) && issue && in_grid) || (state_q == ST_MARK_RD);
	assign wr_en    = (state_q == ST_MARK_WR);

	gsr_ram #(
		.WIDTH (GRID_SIZE),
		.DEPTH (GRID_SIZE)
	) u_rows (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (r_q[AW-1:0]),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (r_q[AW-1:0]),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			r_q         <= '0;
			c_q         <= '0;
			r0_q        <= '0;
			c0_q        <= '0;
			remain_q    <= '0;
			len_q       <= '0;
			head_q      <= HEAD_NORTH;
			ok_q        <= 1'b0;
			out_valid_q <= 1'b0;
			placed_q    <= 1'b0;
			row_valid_q <= '0;
			v_s1        <= 1'b0;
			rowv_s1     <= 1'b0;
			col_s1      <= '0;
		end else begin
			// In ST_DONE the output register is handled by the state itself.
			if (out_valid_q && !out_stall && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						r_q      <= {1'b0, start_row};
						c_q      <= {1'b0, start_col};
						r0_q     <= {1'b0, start_row};
						c0_q     <= {1'b0, start_col};
						remain_q <= run_length;
						len_q    <= run_length;
						head_q   <= heading_t'(heading);
						v_s1     <= 1'b0;
						if (command == CMD_CLEAR) begin
							row_valid_q <= '0;
							ok_q        <= 1'b1;
							state_q     <= ST_DONE;
						end else if (run_length == '0) begin
							ok_q    <= 1'b1;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_CHECK;
						end
					end
				end
				ST_CHECK: begin
					// The cell read last cycle is judged while the next one is read.
					if (cell_hit || (issue && !in_grid)) begin
						ok_q    <= 1'b0;
						v_s1    <= 1'b0;
						state_q <= ST_DONE;
					end else if (!issue && !v_s1) begin
						r_q      <= r0_q;
						c_q      <= c0_q;
						remain_q <= len_q;
						state_q  <= ST_MARK_RD;
					end else begin
						v_s1 <= issue;
						if (issue) begin
							col_s1   <= c_q[AW-1:0];
							rowv_s1  <= row_valid_q[r_q[AW-1:0]];
							r_q      <= r_next;
							c_q      <= c_next;
							remain_q <= remain_q - LEN_W'(1);
						end
					end
				end
				ST_MARK_RD: begin
					rowv_s1 <= row_valid_q[r_q[AW-1:0]];
					state_q <= ST_MARK_WR;
				end
				ST_MARK_WR: begin
					row_valid_q[r_q[AW-1:0]] <= 1'b1;
					r_q      <= r_next;
					c_q      <= c_next;
					remain_q <= remain_q - LEN_W'(1);
					if (remain_q == LEN_W'(1)) begin
						ok_q    <= 1'b1;
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_MARK_RD;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						placed_q    <= ok_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign placed    = placed_q;

endmodule

>>> rtl/gsr_checker.sv
module gsr_checker import gsr_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       command,
	input logic [4:0] run_length,
	input logic       out_valid,
	input logic       out_stall,
	input logic       placed
);

	logic in_xfer;
	assign in_xfer = in_valid && !in_stall;

	// Only one item is in work: the input stalls right after a transfer.
	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> in_stall)
		else $error("input not stalled after a transfer");

	// A new result appears only while an item was in work.
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared with no item in work");

	// A clear or an empty run always succeeds.
	a_trivial_success: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && !out_valid && (command == CMD_CLEAR || run_length == '0))
			|=> ##1 (out_valid && placed))
		else $error("clear or empty run did not report success");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(placed)))
		else $error("stalled result changed");

endmodule

bind grid_segment_reserve_unit gsr_checker u_gsr_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.command    (command),
	.run_length (run_length),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.placed     (placed)
);

>>> test/grid_segment_reserve_unit_tb.sv
`timescale 1ns / 100ps

module grid_segment_reserve_unit_tb;
	import gsr_pkg::*;

	localparam int GRID = 16;
	localparam int RANDOM_ITEMS = 1750;
	localparam int MAX_CYCLES = 1000000;
	localparam int DRAIN_CYCLES = 3 * 31 + 3 + 10;

	typedef struct {
		logic       cmd;
		logic [4:0] row;
		logic [4:0] col;
		heading_t   hd;
		logic [4:0] len;
	} seg_cmd_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic       command;
	logic [4:0] start_row;
	logic [4:0] start_col;
	logic [1:0] heading;
	logic [4:0] run_length;
	logic       out_valid;
	logic       out_stall;
	logic       placed;

	seg_cmd_t pending_cmds[$];
	seg_cmd_t cur_cmd;
	logic     placed_expected[$];
	logic     grid_occ[GRID][GRID];

	int errors;
	int issued_count;
	int gap_left;
	int results_seen;
	int stall_left;
	int hold_left;
	int placed_count;
	int blocked_count;
	int cycle_count;

	grid_segment_reserve_unit #(
		.GRID_SIZE(GRID)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.command   (command),
		.start_row (start_row),
		.start_col (start_col),
		.heading   (heading),
		.run_length(run_length),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.placed    (placed)
	);

	// Applies one command to the local copy of the occupancy grid and returns
	// the expected placed flag.
	function automatic logic reserve_segment(seg_cmd_t c);
		int r;
		int q;
		int dr;
		int dq;
		int k;
		logic ok;
		if (c.cmd == CMD_CLEAR) begin
			foreach (grid_occ[i, j]) grid_occ[i][j] = 1'b0;
			return 1'b1;
		end
		dr = 0;
		dq = 0;
		case (c.hd)
			HEAD_NORTH: dr = -1;
			HEAD_SOUTH: dr = 1;
			HEAD_EAST:  dq = 1;
			default:    dq = -1;
		endcase
		ok = 1'b1;
		r = c.row;
		q = c.col;
		for (k = 0; k < c.len; k++) begin
			if (r < 0 || r >= GRID || q < 0 || q >= GRID || grid_occ[r][q]) begin
				ok = 1'b0;
				break;
			end
			r += dr;
			q += dq;
		end
		if (ok) begin
			r = c.row;
			q = c.col;
			for (k = 0; k < c.len; k++) begin
				grid_occ[r][q] = 1'b1;
				r += dr;
				q += dq;
			end
		end
		return ok;
	endfunction

	function automatic int draw_wait(int idx);
		// Every fourth stretch of items runs with no idling at all.
		if ((idx / 150) % 4 == 3)
			return 0;
		return $urandom_range(0, 4);
	endfunction

	task automatic add_cmd(logic cmd, int row, int col, heading_t hd, int len);
		seg_cmd_t c;
		c.cmd = cmd;
		c.row = row[4:0];
		c.col = col[4:0];
		c.hd  = hd;
		c.len = len[4:0];
		pending_cmds.push_back(c);
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		foreach (grid_occ[i, j]) grid_occ[i][j] = 1'b0;
	end

	// Driver: presents queued commands, predicts each one on its transfer.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid   <= 1'b0;
			command    <= CMD_PLACE;
			start_row  <= '0;
			start_col  <= '0;
			heading    <= HEAD_NORTH;
			run_length <= '0;
			gap_left   = 0;
		end else begin
			if (in_valid && !in_stall)
				placed_expected.push_back(reserve_segment(cur_cmd));
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_cmds.size() > 0) begin
					cur_cmd = pending_cmds.pop_front();
					command    <= cur_cmd.cmd;
					start_row  <= cur_cmd.row;
					start_col  <= cur_cmd.col;
					heading    <= cur_cmd.hd;
					run_length <= cur_cmd.len;
					in_valid   <= 1'b1;
					gap_left = draw_wait(issued_count);
					issued_count++;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each result transfer against the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_left = 0;
			hold_left  = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (placed_expected.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual placed=%0b",
						$time, placed);
					errors++;
				end else begin
					logic exp_placed;
					exp_placed = placed_expected.pop_front();
					if (placed !== exp_placed) begin
						$display("%0t: placed mismatch, expected %0b, actual %0b",
							$time, exp_placed, placed);
						errors++;
					end
				end
				if (placed === 1'b1)
					placed_count++;
				else
					blocked_count++;
				results_seen++;
				stall_left = draw_wait(results_seen);
				// Long hold-offs let the sender back up against a full block.
				if (results_seen == 400 || results_seen == 1200)
					hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= MAX_CYCLES) begin
			$display("%0t: timeout after %0d cycles", $time, cycle_count);
			$display("grid_segment_reserve_unit_tb: FAIL");
			$finish;
		end
	end

	initial begin
		int n;
		int pick;
		int len;
		errors = 0;
		issued_count = 0;
		results_seen = 0;
		placed_count = 0;
		blocked_count = 0;
		cycle_count = 0;
		arst_n = 1'b0;

		// Directed part: edges, wraps, overlaps, zero length and clears.
		add_cmd(CMD_CLEAR, 31, 31, HEAD_WEST, 31);
		add_cmd(CMD_PLACE, 31, 31, HEAD_NORTH, 0);
		add_cmd(CMD_PLACE, 0, 0, HEAD_NORTH, 1);
		add_cmd(CMD_PLACE, 0, 0, HEAD_SOUTH, 1);
		add_cmd(CMD_PLACE, 1, 5, HEAD_NORTH, 3);
		add_cmd(CMD_PLACE, 15, 15, HEAD_SOUTH, 1);
		add_cmd(CMD_PLACE, 14, 14, HEAD_EAST, 2);
		add_cmd(CMD_PLACE, 13, 14, HEAD_EAST, 3);
		add_cmd(CMD_PLACE, 5, 0, HEAD_WEST, 2);
		add_cmd(CMD_PLACE, 16, 3, HEAD_EAST, 1);
		add_cmd(CMD_PLACE, 3, 16, HEAD_SOUTH, 0);
		add_cmd(CMD_PLACE, 4, 0, HEAD_EAST, 16);
		add_cmd(CMD_PLACE, 4, 7, HEAD_SOUTH, 1);
		add_cmd(CMD_PLACE, 0, 8, HEAD_SOUTH, 16);
		add_cmd(CMD_PLACE, 0, 8, HEAD_SOUTH, 4);
		add_cmd(CMD_PLACE, 31, 31, HEAD_WEST, 31);
		add_cmd(CMD_PLACE, 0, 31, HEAD_WEST, 1);
		add_cmd(CMD_PLACE, 15, 0, HEAD_NORTH, 31);
		add_cmd(CMD_PLACE, 15, 9, HEAD_NORTH, 11);
		add_cmd(CMD_CLEAR, 0, 0, HEAD_NORTH, 0);
		add_cmd(CMD_PLACE, 4, 7, HEAD_SOUTH, 1);
		add_cmd(CMD_PLACE, 15, 15, HEAD_WEST, 16);
		add_cmd(CMD_PLACE, 0, 15, HEAD_SOUTH, 16);

		// Random part: mostly in-grid runs of modest length, with clears to
		// keep the grid from saturating and some fully random noise.
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 5) begin
				add_cmd(CMD_CLEAR, $urandom_range(0, 31), $urandom_range(0, 31),
					heading_t'($urandom_range(0, 3)), $urandom_range(0, 31));
			end else if (pick < 15) begin
				add_cmd(CMD_PLACE, $urandom_range(0, 31), $urandom_range(0, 31),
					heading_t'($urandom_range(0, 3)), $urandom_range(0, 31));
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 5)
					len = 0;
				else if (pick < 85)
					len = $urandom_range(1, 6);
				else
					len = $urandom_range(7, GRID);
				add_cmd(CMD_PLACE, $urandom_range(0, GRID - 1), $urandom_range(0, GRID - 1),
					heading_t'($urandom_range(0, 3)), len);
			end
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_cmds.size() != 0 || in_valid || placed_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d results: %0d placed or cleared, %0d blocked or off grid.",
			results_seen, placed_count, blocked_count);
		$display("Random gaps and stalls on both sides, two long output hold-offs.");
		if (errors == 0 && placed_expected.size() == 0) begin
			$display("grid_segment_reserve_unit_tb: PASS");
		end else begin
			$display("%0d errors, %0d results still expected", errors, placed_expected.size());
			$display("grid_segment_reserve_unit_tb: FAIL");
		end
		$finish;
	end

endmodule
